// ===== src/max_xor_subarray_trie_core_assert.svh =====
// Assertion macros for the max XOR subarray trie core.
`ifndef MAX_XOR_SUBARRAY_TRIE_CORE_ASSERT_SVH
`define MAX_XOR_SUBARRAY_TRIE_CORE_ASSERT_SVH
`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define MXST_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mxst assertion failed");
// Check a property on every rising edge, reset included.
`define MXST_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mxst assertion failed");
`else
`define MXST_ASSERT(label, clk, rst, prop)
`define MXST_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== src/mxst_pkg.sv =====
`timescale 1ns / 1ps
package mxst_pkg;

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_IREAD = 6'b000010,
    S_BUILD = 6'b000100,
    S_LEAF  = 6'b001000,
    S_SREAD = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

endpackage

// ===== src/mxst_ram.sv =====
`timescale 1ns / 1ps
module mxst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/max_xor_subarray_trie_core.sv =====
`timescale 1ns / 1ps
`include "max_xor_subarray_trie_core_assert.svh"
// Largest XOR of any contiguous subarray of a word stream. Each request brings
// one word and a first flag that starts a new sequence; the block keeps the
// running prefix XOR, stores every prefix in a binary trie held in one RAM of
// 1 + VALUE_BITS * (MAX_ITEMS + 1) nodes (two child links per word), and
// answers each request with one result. The trie is walked one level per
// cycle, one RAM access per level, with the key shifted out one bit a cycle.
// A request whose prefix is already stored writes no new nodes, and once the
// trie is full the insert walk is skipped. On the first request of a sequence
// the empty prefix is first written in as a chain of new nodes. The next
// request can be taken in the cycle in which the result is first presented.
// Only one request is in work at a time; a finished result waits in the
// output register while the next request is taken.
// Once MAX_ITEMS words are stored, later words are still searched but not
// stored, and overflow is set. No clearing pass is needed after reset: every
// node is written in full when it is allocated.
module max_xor_subarray_trie_core import mxst_pkg::*; #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_ITEMS  = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value,
  input  logic        first,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] max_xor,
  output logic        overflow
);

  localparam int NODE_CAP = 1 + VALUE_BITS * (MAX_ITEMS + 1);
  localparam int NW       = $clog2(NODE_CAP);
  localparam int NCW      = $clog2(NODE_CAP + 1);
  localparam int ICW      = $clog2(MAX_ITEMS + 1);
  localparam int LW       = $clog2(VALUE_BITS);
  localparam int EW       = 2 * NW;

  localparam logic [ICW-1:0] ITEM_MAX = ICW'(MAX_ITEMS);
  localparam logic [LW-1:0]  LVL_TOP  = LW'(VALUE_BITS - 1);

  state_t                state, state_next;
  logic [LW-1:0]         lvl;
  logic [NW-1:0]         cur, cur_next;
  logic [EW-1:0]         base;
  logic [VALUE_BITS-1:0] key_sh;
  logic [VALUE_BITS-1:0] res;
  logic [VALUE_BITS-1:0] prefix;
  logic [VALUE_BITS-1:0] best;
  logic [NCW-1:0]        node_count;
  logic [ICW-1:0]        item_count;
  logic                  seeding;
  logic                  ovf;

  logic                  we;
  logic [NW-1:0]         waddr;
  logic [EW-1:0]         wdata;
  logic [EW-1:0]         rdata;

  logic                  accept;
  logic                  out_free;
  logic [ICW-1:0]        ic_eff;
  logic [VALUE_BITS-1:0] pfx_new;
  logic                  key_bit;
  logic [NW-1:0]         link0, link1, taken, c_want, c_other, alloc;
  logic                  hit;
  logic [EW-1:0]         build_wd;
  logic [VALUE_BITS-1:0] final_best;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign ic_eff  = first ? '0 : item_count;
  assign pfx_new = (first ? '0 : prefix) ^ VALUE_BITS'(value);

  assign key_bit = key_sh[VALUE_BITS-1];
  assign link0   = rdata[NW-1:0];
  assign link1   = rdata[EW-1:NW];
  assign taken   = key_bit ? link1 : link0;
  // Search prefers the branch opposite to the key bit.
  assign c_want  = key_bit ? link0 : link1;
  assign c_other = key_bit ? link1 : link0;
  assign hit     = (c_want != '0);

  assign alloc    = node_count[NW-1:0];
  assign build_wd = key_bit ? {alloc, base[NW-1:0]} : {base[EW-1:NW], alloc};

  assign final_best = (res > best) ? res : best;

  always_comb begin
    state_next = state;
    cur_next   = cur;
    we         = 1'b0;
    waddr      = cur;
    wdata      = build_wd;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cur_next = '0;
          if (ic_eff == '0) begin
            state_next = S_BUILD;
          end else if (ic_eff == ITEM_MAX) begin
            state_next = S_SREAD;
          end else begin
            state_next = S_IREAD;
          end
        end
      end
      S_IREAD: begin
        if (taken != '0) begin
          cur_next = taken;
          if (lvl == '0) begin
            cur_next   = '0;
            state_next = S_SREAD;
          end
        end else begin
          state_next = S_BUILD;
        end
      end
      S_BUILD: begin
        we       = 1'b1;
        cur_next = alloc;
        if (lvl == '0) begin
          state_next = S_LEAF;
        end
      end
      S_LEAF: begin
        we       = 1'b1;
        wdata    = '0;
        cur_next = '0;
        state_next = seeding ? S_IREAD : S_SREAD;
      end
      S_SREAD: begin
        cur_next = hit ? c_want : c_other;
        if (lvl == '0) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  mxst_ram #(
    .WIDTH(EW),
    .DEPTH(NODE_CAP)
  ) u_links (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cur_next),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= NCW'(1);
      item_count <= '0;
      prefix     <= '0;
      best       <= '0;
      seeding    <= 1'b0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      // Drop the result once taken, unless a new one is loaded this cycle.
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            prefix  <= pfx_new;
            key_sh  <= (ic_eff == '0) ? '0 : pfx_new;
            base    <= '0;
            lvl     <= LVL_TOP;
            seeding <= (ic_eff == '0);
            ovf     <= (ic_eff == ITEM_MAX);
            item_count <= (ic_eff == ITEM_MAX) ? ic_eff : ic_eff + ICW'(1);
            if (first) begin
              best       <= '0;
              node_count <= NCW'(1);
            end
          end
        end
        S_IREAD: begin
          if (taken != '0) begin
            if (lvl == '0) begin
              // Prefix already stored: reload the key for the search walk.
              key_sh <= prefix;
              lvl    <= LVL_TOP;
            end else begin
              key_sh <= {key_sh[VALUE_BITS-2:0], 1'b0};
              lvl    <= lvl - LW'(1);
            end
          end else begin
            base <= rdata;
          end
        end
        S_BUILD: begin
          node_count <= node_count + NCW'(1);
          base       <= '0;
          key_sh     <= {key_sh[VALUE_BITS-2:0], 1'b0};
          if (lvl != '0) begin
            lvl <= lvl - LW'(1);
          end
        end
        S_LEAF: begin
          key_sh  <= prefix;
          lvl     <= LVL_TOP;
          seeding <= 1'b0;
        end
        S_SREAD: begin
          res    <= {res[VALUE_BITS-2:0], hit};
          key_sh <= {key_sh[VALUE_BITS-2:0], 1'b0};
          if (lvl != '0) begin
            lvl <= lvl - LW'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            best      <= final_best;
            max_xor   <= 32'(final_best);
            overflow  <= ovf;
            out_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  `MXST_ASSERT(a_node_cap, clk, rst, node_count <= NCW'(NODE_CAP))
  `MXST_ASSERT(a_alloc_ahead, clk, rst, (state == S_BUILD || state == S_LEAF) |-> (node_count > NCW'(cur)))
  `MXST_ASSERT(a_result_from_fin, clk, rst, $rose(out_valid) |-> $past(state == S_FIN))
  `MXST_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> (!out_valid && !in_stall))

endmodule
